@@ rtl/sha1_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the SHA-1 digest block.
// Used by sha1_ctrl, sha1_dp and sha1_message_digest_top; depends on nothing.
package sha1_pkg;

   localparam int NUM_DIGEST_WORDS = 5;
   localparam int NUM_SCHED_WORDS  = 16;
   localparam int LANES_PER_WORD   = 4;

   localparam logic [2:0] LAST_INDEX = 3'd4;
   localparam logic [5:0] FILL_LAST  = 6'd63;
   localparam logic [5:0] FILL_LEN   = 6'd56;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam logic [1:0] BSEL_DATA = 2'd0;
   localparam logic [1:0] BSEL_PAD  = 2'd1;
   localparam logic [1:0] BSEL_ZERO = 2'd2;
   localparam logic [1:0] BSEL_LEN  = 2'd3;

   localparam logic [1:0] PHASE_CH  = 2'd0;
   localparam logic [1:0] PHASE_PAR = 2'd1;
   localparam logic [1:0] PHASE_MAJ = 2'd2;
   localparam logic [1:0] PHASE_PAR2 = 2'd3;

   typedef struct packed {
      logic       write_en;
      logic [1:0] byte_sel;
      logic       round_en;
      logic [1:0] phase;
      logic       final_add;
      logic       out_step;
   } sha1_cmd_type;

   typedef struct packed {
      logic [5:0] fill;
      logic       out_last;
   } sha1_status_type;

   function automatic logic [31:0] init_word(input logic [2:0] idx);
      logic [31:0] val;
      case (idx)
         3'd0:    val = 32'h67452301;
         3'd1:    val = 32'hefcdab89;
         3'd2:    val = 32'h98badcfe;
         3'd3:    val = 32'h10325476;
         default: val = 32'hc3d2e1f0;
      endcase
      return val;
   endfunction

   function automatic logic [31:0] round_k(input logic [1:0] phase);
      logic [31:0] val;
      case (phase)
         PHASE_CH:  val = 32'h5a827999;
         PHASE_PAR: val = 32'h6ed9eba1;
         PHASE_MAJ: val = 32'h8f1bbcdc;
         default:   val = 32'hca62c1d6;
      endcase
      return val;
   endfunction

endpackage

@@ rtl/sha1_dp.sv @@
`timescale 1ns / 1ps
// Datapath: block word buffer and schedule, round registers, chaining value,
// fill count, message length and digest word select. Uses sha1_pkg.
module sha1_dp import sha1_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  sha1_cmd_type    cmd,
   input  logic [7:0]      data_byte,
   output sha1_status_type status,
   output logic [31:0]     digest_word,
   output logic [2:0]      word_index,
   output logic            last_word
);

   logic [31:0] w_ff [NUM_SCHED_WORDS];
   logic [31:0] w_in [NUM_SCHED_WORDS];
   logic [31:0] cv_ff [NUM_DIGEST_WORDS];
   logic [31:0] cv_in [NUM_DIGEST_WORDS];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in;
   logic [5:0]  fill_ff, fill_in;
   logic [60:0] total_ff, total_in;
   logic [2:0]  idx_ff, idx_in;
   logic [7:0]  wr_byte;
   logic [63:0] len_shift;
   logic [31:0] w_mix, w_new, f_val, t_val;

   always_comb begin
      len_shift = {total_ff, 3'b000} << {fill_ff[2:0], 3'b000};
      case (cmd.byte_sel)
         BSEL_DATA: wr_byte = data_byte;
         BSEL_PAD:  wr_byte = PAD_BYTE;
         BSEL_ZERO: wr_byte = 8'h00;
         BSEL_LEN:  wr_byte = len_shift[63:56];
         default:   wr_byte = 8'h00;
      endcase

      w_mix = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
      w_new = {w_mix[30:0], w_mix[31]};

      case (cmd.phase)
         PHASE_CH:  f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         PHASE_MAJ: f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         default:   f_val = b_ff ^ c_ff ^ d_ff;
      endcase
      t_val = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + w_ff[0] + round_k(cmd.phase);

      w_in     = w_ff;
      cv_in    = cv_ff;
      fill_in  = fill_ff;
      total_in = total_ff;
      idx_in   = idx_ff;

      if (cmd.round_en) begin
         for (int j = 0; j < NUM_SCHED_WORDS - 1; j++) begin
            w_in[j] = w_ff[j + 1];
         end
         w_in[NUM_SCHED_WORDS - 1] = w_new;
         a_in = t_val;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[31:2]};
         d_in = c_ff;
         e_in = d_ff;
      end else begin
         a_in = cv_ff[0];
         b_in = cv_ff[1];
         c_in = cv_ff[2];
         d_in = cv_ff[3];
         e_in = cv_ff[4];
      end

      if (cmd.write_en) begin
         for (int j = 0; j < NUM_SCHED_WORDS; j++) begin
            for (int k = 0; k < LANES_PER_WORD; k++) begin
               if (fill_ff[5:2] == 4'(j) && fill_ff[1:0] == 2'(k)) begin
                  w_in[j][31 - 8 * k -: 8] = wr_byte;
               end
            end
         end
         fill_in = fill_ff + 6'd1;
         if (cmd.byte_sel == BSEL_DATA) begin
            total_in = total_ff + 61'd1;
         end
      end

      if (cmd.final_add) begin
         cv_in[0] = cv_ff[0] + a_ff;
         cv_in[1] = cv_ff[1] + b_ff;
         cv_in[2] = cv_ff[2] + c_ff;
         cv_in[3] = cv_ff[3] + d_ff;
         cv_in[4] = cv_ff[4] + e_ff;
      end

      if (cmd.out_step) begin
         if (idx_ff == LAST_INDEX) begin
            idx_in   = 3'd0;
            total_in = '0;
            for (int i = 0; i < NUM_DIGEST_WORDS; i++) begin
               cv_in[i] = init_word(3'(i));
            end
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DIGEST_WORDS; i++) begin
            cv_ff[i] <= init_word(3'(i));
         end
         fill_ff  <= '0;
         total_ff <= '0;
         idx_ff   <= '0;
      end else begin
         cv_ff    <= cv_in;
         fill_ff  <= fill_in;
         total_ff <= total_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      e_ff <= e_in;
   end

   always_comb begin
      case (idx_ff)
         3'd0:    digest_word = cv_ff[0];
         3'd1:    digest_word = cv_ff[1];
         3'd2:    digest_word = cv_ff[2];
         3'd3:    digest_word = cv_ff[3];
         default: digest_word = cv_ff[4];
      endcase
   end

   assign word_index      = idx_ff;
   assign last_word       = (idx_ff == LAST_INDEX);
   assign status.fill     = fill_ff;
   assign status.out_last = (idx_ff == LAST_INDEX);

endmodule

@@ rtl/sha1_ctrl.sv @@
`timescale 1ns / 1ps
// Controller: sequences byte intake, padding, the 80 compression rounds
// and digest transfers. Uses sha1_pkg; drives the datapath in sha1_dp.
module sha1_ctrl import sha1_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_has_byte,
   input  logic            req_end_of_message,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  sha1_status_type status,
   output sha1_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ROUND = 3'd1;
   localparam logic [2:0] S_FINAL = 3'd2;
   localparam logic [2:0] S_PAD80 = 3'd3;
   localparam logic [2:0] S_ZFULL = 3'd4;
   localparam logic [2:0] S_ZERO  = 3'd5;
   localparam logic [2:0] S_LEN   = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   localparam logic [1:0] RET_IDLE = 2'd0;
   localparam logic [1:0] RET_PAD  = 2'd1;
   localparam logic [1:0] RET_ZERO = 2'd2;
   localparam logic [1:0] RET_OUT  = 2'd3;

   localparam logic [6:0] ROUND_LAST = 7'd79;

   logic [2:0] state_ff, state_in;
   logic [1:0] ret_ff, ret_in;
   logic [6:0] cnt_ff, cnt_in;
   logic       accept;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      ret_in    = ret_ff;
      cnt_in    = cnt_ff;
      req_stall = (state_ff != S_IDLE);
      rsp_valid = (state_ff == S_OUT);
      accept    = req_valid && !req_stall;

      if (cnt_ff < 7'd20) begin
         cmd.phase = PHASE_CH;
      end else if (cnt_ff < 7'd40) begin
         cmd.phase = PHASE_PAR;
      end else if (cnt_ff < 7'd60) begin
         cmd.phase = PHASE_MAJ;
      end else begin
         cmd.phase = PHASE_PAR2;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_has_byte) begin
                  cmd.write_en = 1'b1;
                  cmd.byte_sel = BSEL_DATA;
               end
               if (req_has_byte && status.fill == FILL_LAST) begin
                  state_in = S_ROUND;
                  cnt_in   = '0;
                  ret_in   = req_end_of_message ? RET_PAD : RET_IDLE;
               end else if (req_end_of_message) begin
                  state_in = S_PAD80;
               end
            end
         end
         S_ROUND: begin
            cmd.round_en = 1'b1;
            if (cnt_ff == ROUND_LAST) begin
               state_in = S_FINAL;
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end
         S_FINAL: begin
            cmd.final_add = 1'b1;
            case (ret_ff)
               RET_PAD:  state_in = S_PAD80;
               RET_ZERO: state_in = S_ZERO;
               RET_OUT:  state_in = S_OUT;
               default:  state_in = S_IDLE;
            endcase
         end
         S_PAD80: begin
            cmd.write_en = 1'b1;
            cmd.byte_sel = BSEL_PAD;
            if (status.fill == FILL_LAST) begin
               state_in = S_ROUND;
               cnt_in   = '0;
               ret_in   = RET_ZERO;
            end else if (status.fill >= FILL_LEN) begin
               state_in = S_ZFULL;
            end else begin
               state_in = S_ZERO;
            end
         end
         S_ZFULL: begin
            cmd.write_en = 1'b1;
            cmd.byte_sel = BSEL_ZERO;
            if (status.fill == FILL_LAST) begin
               state_in = S_ROUND;
               cnt_in   = '0;
               ret_in   = RET_ZERO;
            end
         end
         S_ZERO: begin
            if (status.fill == FILL_LEN) begin
               state_in = S_LEN;
            end else begin
               cmd.write_en = 1'b1;
               cmd.byte_sel = BSEL_ZERO;
            end
         end
         S_LEN: begin
            cmd.write_en = 1'b1;
            cmd.byte_sel = BSEL_LEN;
            if (status.fill == FILL_LAST) begin
               state_in = S_ROUND;
               cnt_in   = '0;
               ret_in   = RET_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               cmd.out_step = 1'b1;
               if (status.out_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= RET_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         cnt_ff   <= cnt_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_valid && !req_stall))
      else $error("input transfer taken while digest is pending");

   a_final_after_rounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FINAL |-> $past(state_ff) == S_ROUND && $past(cnt_ff) == ROUND_LAST)
      else $error("chaining update without a full set of rounds");

   a_out_block_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> status.fill == '0)
      else $error("digest shown with a partial block held");

   a_len_position: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LEN |-> status.fill >= FILL_LEN)
      else $error("length byte written outside the tail of the block");
`endif

endmodule

@@ rtl/sha1_message_digest_top.sv @@
`timescale 1ns / 1ps
// SHA-1 digest engine, top level: joins controller and datapath.
// Depends on sha1_pkg, sha1_ctrl and sha1_dp.
//
// Feed the message one byte per transfer; the transfer that completes a
// 64-byte block is followed by 80 rounds (S_ROUND) and one chaining update
// (S_FINAL), all on a single round unit running one round per cycle.
// The transfer marked end_of_message starts padding, written one byte per
// cycle except for a turn state (S_ZERO) before the length bytes, with one or
// two compressions; the five digest words then leave as five result
// transfers, word 0 first, and the engine returns to the initial chaining
// value. req_stall stays high through each compression and from the end
// transfer until the last digest word is taken.
module sha1_message_digest_top import sha1_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   sha1_cmd_type    cmd;
   sha1_status_type status;

   sha1_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_has_byte       (req_has_byte),
      .req_end_of_message (req_end_of_message),
      .req_stall          (req_stall),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .status             (status),
      .cmd                (cmd)
   );

   sha1_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_data_byte),
      .status      (status),
      .digest_word (rsp_digest_word),
      .word_index  (rsp_word_index),
      .last_word   (rsp_last_word)
   );

endmodule
